[rtl/tgrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tgrt_pkg;

	localparam int MAP_CELLS_DEF   = 4096;
	localparam int MAX_TARGETS_DEF = 8;
	localparam int FRAC_BITS_DEF   = 8;

	localparam int DIST_W = 38;
	localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

	localparam int PADDR_W = 4;

	localparam logic [1:0] KIND_MAP    = 2'd0;
	localparam logic [1:0] KIND_TARGET = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_CAST   = 2'd3;

	localparam logic [1:0] STATUS_HIT    = 2'd0;
	localparam logic [1:0] STATUS_MISS   = 2'd1;
	localparam logic [1:0] STATUS_NOLOAD = 2'd2;

	localparam logic [1:0] REG_TILE_W = 2'd0;
	localparam logic [1:0] REG_TILE_H = 2'd1;
	localparam logic [1:0] REG_MAP_W  = 2'd2;
	localparam logic [1:0] REG_MAP_H  = 2'd3;

	localparam logic OP_DIV  = 1'b0;
	localparam logic OP_SQRT = 1'b1;

	typedef struct packed {
		logic [1:0]         kind;
		logic [11:0]        slot;
		logic [15:0]        tile_value;
		logic signed [23:0] start_x;
		logic signed [23:0] start_y;
		logic signed [23:0] end_x;
		logic signed [23:0] end_y;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [5:0]         hit_tile_x;
		logic [5:0]         hit_tile_y;
		logic [11:0]        hit_tile_index;
		logic [15:0]        hit_tile_type;
		logic signed [23:0] hit_x;
		logic signed [23:0] hit_y;
		logic               hit_side;
	} res_t;

	typedef struct packed {
		logic        go;
		logic        op;
		logic [6:0]  n;
		logic [63:0] a;
		logic [24:0] b;
	} iter_cmd_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
		logic [24:0] rem;
	} iter_rsp_t;

endpackage
`default_nettype wire

[rtl/tgrt_iter.sv]
`timescale 1ns / 1ps
`default_nettype none
// shift-subtract unit: divide one bit or square root two bits per cycle
// operand a arrives left aligned so that n steps consume exactly its valid bits
module tgrt_iter (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tgrt_pkg::iter_cmd_t cmd,
	output tgrt_pkg::iter_rsp_t      rsp
);

	logic        busy_q;
	logic        done_q;
	logic        op_q;
	logic [6:0]  cnt_q;
	logic [63:0] num_q;
	logic [27:0] rem_q;
	logic [63:0] quo_q;
	logic [24:0] div_q;

	logic [27:0] trial;
	logic [27:0] part;
	logic        take;

	always_comb begin
		if (op_q == tgrt_pkg::OP_SQRT) begin
			part  = {rem_q[25:0], num_q[63:62]};
			trial = {1'b0, quo_q[24:0], 2'b01};
		end else begin
			part  = {rem_q[26:0], num_q[63]};
			trial = {3'b000, div_q};
		end
		take = (part >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.n;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			op_q  <= cmd.op;
			num_q <= cmd.a;
			div_q <= cmd.b;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? (part - trial) : part;
			quo_q <= {quo_q[62:0], take};
			num_q <= (op_q == tgrt_pkg::OP_SQRT) ? {num_q[61:0], 2'b00} : {num_q[62:0], 1'b0};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q[24:0];

endmodule
`default_nettype wire

[rtl/tile_grid_ray_traversal.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   | signals                               | handshake
// request   | start, busy, req                      | taken when start high and busy low
// result    | done, result                          | one cycle pulse, cannot be held off
// config    | psel, penable, pwrite, paddr, pwdata  | written in access phase, pready tied high
//
// map, target and clear requests leave busy low.
// a cast runs its setup (squares, sqrt, two step divides, two
// tile divides in the shared shift-subtract unit), then STEP and LOOK per pixel
// crossing, plus CMP for an in-map one, and on a hit ends with the hit point divides.
// a cast with no map or no targets answers in the next cycle without going busy.
// reset clears the sequencer, the loaded flags and the configuration registers; stores need no clearing.
module tile_grid_ray_traversal #(
	parameter int MAP_CELLS   = tgrt_pkg::MAP_CELLS_DEF,
	parameter int MAX_TARGETS = tgrt_pkg::MAX_TARGETS_DEF,
	parameter int FRAC_BITS   = tgrt_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire tgrt_pkg::req_t               req,
	output logic                              done,
	output tgrt_pkg::res_t                    result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [tgrt_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int AW   = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
	localparam int XW   = ((AW > 12) ? AW : 12) + 1;
	localparam int TIW  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CNTW = $clog2(MAX_TARGETS + 1);
	localparam int CXW  = 26 - FRAC_BITS;
	localparam int CMW  = (CXW > 16) ? CXW : 16;
	localparam int DW   = tgrt_pkg::DIST_W;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_MULX = 5'd1;
	localparam logic [4:0] ST_MULY = 5'd2;
	localparam logic [4:0] ST_SQRT = 5'd3;
	localparam logic [4:0] ST_SQW  = 5'd4;
	localparam logic [4:0] ST_DVX  = 5'd5;
	localparam logic [4:0] ST_DVXW = 5'd6;
	localparam logic [4:0] ST_DVY  = 5'd7;
	localparam logic [4:0] ST_DVYW = 5'd8;
	localparam logic [4:0] ST_FX0  = 5'd9;
	localparam logic [4:0] ST_FX1  = 5'd10;
	localparam logic [4:0] ST_FX2  = 5'd11;
	localparam logic [4:0] ST_FY0  = 5'd12;
	localparam logic [4:0] ST_FY1  = 5'd13;
	localparam logic [4:0] ST_FY2  = 5'd14;
	localparam logic [4:0] ST_TX   = 5'd15;
	localparam logic [4:0] ST_TXW  = 5'd16;
	localparam logic [4:0] ST_TY   = 5'd17;
	localparam logic [4:0] ST_TYW  = 5'd18;
	localparam logic [4:0] ST_STEP = 5'd19;
	localparam logic [4:0] ST_LOOK = 5'd20;
	localparam logic [4:0] ST_CMP  = 5'd21;
	localparam logic [4:0] ST_HX0  = 5'd22;
	localparam logic [4:0] ST_HX1  = 5'd23;
	localparam logic [4:0] ST_HX2  = 5'd24;
	localparam logic [4:0] ST_HXW  = 5'd25;
	localparam logic [4:0] ST_HY0  = 5'd26;
	localparam logic [4:0] ST_HY1  = 5'd27;
	localparam logic [4:0] ST_HY2  = 5'd28;
	localparam logic [4:0] ST_HYW  = 5'd29;

	// configuration
	logic [8:0] tile_width_q, tile_height_q;
	logic [6:0] map_width_q, map_height_q;
	logic       cfg_wr;

	// stores
	logic [15:0]     tile_mem [MAP_CELLS];
	logic [15:0]     targ_q [MAX_TARGETS];
	logic            map_loaded_q;
	logic [CNTW-1:0] target_count_q;

	// sequencer and cast state
	logic [4:0]              state_q;
	logic                    done_q;
	tgrt_pkg::res_t          res_q;
	logic signed [23:0]      sx_q, sy_q, hx_q;
	logic signed [24:0]      dx_q, dy_q;
	logic [23:0]             ax_q, ay_q;
	logic [24:0]             len_q;
	logic [DW-1:0]           stx_q, sty_q, lx_q, ly_q, dist_q;
	logic signed [CXW-1:0]   cx_q, cy_q;
	logic [5:0]              tx_q, ty_q;
	logic [7:0]              ox_q, oy_q;
	logic                    side_q;
	logic [63:0]             acc_q;
	logic [49:0]             prod_q;
	logic [11:0]             idx_q;
	logic [15:0]             rd_q;

	// combinational
	logic [8:0]          tw, th;
	logic [6:0]          mw, mh;
	logic [15:0]         mwtw, mhth;
	logic [7:0]          tw_m1, th_m1;
	logic                accept;
	logic                xneg, yneg;
	logic                xin, yin;
	logic [FRAC_BITS:0]  part_x, part_y;
	logic [24:0]         mul_a, mul_b;
	logic [63:0]         pair_sum;
	logic [DW:0]         lx_sum, ly_sum;
	logic [DW-1:0]       lx_nx, ly_nx;
	logic [5:0]          tx_nx, ty_nx;
	logic [7:0]          ox_nx, oy_nx;
	logic [11:0]         idx_c;
	logic [XW-1:0]       idx_ext, slot_ext;
	logic                match;
	logic signed [23:0]  cx0, cy0;
	logic signed [24:0]  dx_in, dy_in;
	logic [DW-1:0]       quo_sat;
	logic [CMW-1:0]      cx_u, cy_u;
	tgrt_pkg::iter_cmd_t cmd;
	tgrt_pkg::iter_rsp_t rsp;

	function automatic logic [8:0] clamp_tile(input logic [8:0] v);
		logic [8:0] r;
		r = v;
		if (v == 9'd0) r = 9'd1;
		else if (v > 9'd256) r = 9'd256;
		return r;
	endfunction

	function automatic logic [6:0] clamp_map(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		if (v == 7'd0) r = 7'd1;
		else if (v > 7'd64) r = 7'd64;
		return r;
	endfunction

	// start plus or minus the scaled offset, saturated to 24 bits
	function automatic logic [23:0] hit_coord(input logic signed [23:0] s, input logic neg,
			input logic [63:0] q);
		logic signed [26:0] h;
		logic signed [26:0] qs;
		logic [23:0]        r;
		qs = $signed({2'b00, q[24:0]});
		h  = neg ? (27'(s) - qs) : (27'(s) + qs);
		if (q[63:25] != '0) r = neg ? 24'h800000 : 24'h7fffff;
		else if (h > 27'sd8388607) r = 24'h7fffff;
		else if (h < -27'sd8388608) r = 24'h800000;
		else r = h[23:0];
		return r;
	endfunction

	tgrt_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;
	assign pready = 1'b1;
	assign accept = start && (state_q == ST_IDLE);
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		tw    = clamp_tile(tile_width_q);
		th    = clamp_tile(tile_height_q);
		mw    = clamp_map(map_width_q);
		mh    = clamp_map(map_height_q);
		mwtw  = 16'(mw) * 16'(tw);
		mhth  = 16'(mh) * 16'(th);
		tw_m1 = 8'(tw - 9'd1);
		th_m1 = 8'(th - 9'd1);
	end

	always_comb begin
		case (paddr[3:2])
			tgrt_pkg::REG_TILE_W: prdata = 32'(tile_width_q);
			tgrt_pkg::REG_TILE_H: prdata = 32'(tile_height_q);
			tgrt_pkg::REG_MAP_W:  prdata = 32'(map_width_q);
			tgrt_pkg::REG_MAP_H:  prdata = 32'(map_height_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		dx_in    = 25'(req.end_x) - 25'(req.start_x);
		dy_in    = 25'(req.end_y) - 25'(req.start_y);
		cx0      = req.start_x >>> FRAC_BITS;
		cy0      = req.start_y >>> FRAC_BITS;
		slot_ext = XW'(req.slot);
		xneg     = dx_q[24];
		yneg     = dy_q[24];
		cx_u     = CMW'($unsigned(cx_q));
		cy_u     = CMW'($unsigned(cy_q));
		xin      = !cx_q[CXW-1] && (cx_u < CMW'(mwtw));
		yin      = !cy_q[CXW-1] && (cy_u < CMW'(mhth));
		part_x   = xneg ? (FRAC_BITS+1)'(sx_q[FRAC_BITS-1:0])
			: ((FRAC_BITS+1)'(1) << FRAC_BITS) - (FRAC_BITS+1)'(sx_q[FRAC_BITS-1:0]);
		part_y   = yneg ? (FRAC_BITS+1)'(sy_q[FRAC_BITS-1:0])
			: ((FRAC_BITS+1)'(1) << FRAC_BITS) - (FRAC_BITS+1)'(sy_q[FRAC_BITS-1:0]);
		pair_sum = acc_q + (64'(prod_q) << 19);
		quo_sat  = (rsp.quo > 64'(tgrt_pkg::DIST_SAT)) ? tgrt_pkg::DIST_SAT : rsp.quo[DW-1:0];
		lx_sum   = (DW+1)'(lx_q) + (DW+1)'(stx_q);
		ly_sum   = (DW+1)'(ly_q) + (DW+1)'(sty_q);
		lx_nx    = (lx_sum > (DW+1)'(tgrt_pkg::DIST_SAT)) ? tgrt_pkg::DIST_SAT : lx_sum[DW-1:0];
		ly_nx    = (ly_sum > (DW+1)'(tgrt_pkg::DIST_SAT)) ? tgrt_pkg::DIST_SAT : ly_sum[DW-1:0];
		idx_c    = 12'(12'(ty_q) * 12'(mw)) + 12'(tx_q);
		idx_ext  = XW'(idx_c);
	end

	// tile column and offset follow the pixel one step at a time
	always_comb begin
		tx_nx = tx_q;
		ox_nx = ox_q;
		if (!xneg) begin
			if (cx_q == {CXW{1'b1}}) begin
				tx_nx = '0;
				ox_nx = '0;
			end else if (ox_q == tw_m1) begin
				tx_nx = tx_q + 6'd1;
				ox_nx = '0;
			end else begin
				ox_nx = ox_q + 8'd1;
			end
		end else begin
			if (!cx_q[CXW-1] && cx_u == CMW'(mwtw)) begin
				tx_nx = 6'(mw - 7'd1);
				ox_nx = tw_m1;
			end else if (ox_q == 8'd0) begin
				tx_nx = tx_q - 6'd1;
				ox_nx = tw_m1;
			end else begin
				ox_nx = ox_q - 8'd1;
			end
		end
	end

	always_comb begin
		ty_nx = ty_q;
		oy_nx = oy_q;
		if (!yneg) begin
			if (cy_q == {CXW{1'b1}}) begin
				ty_nx = '0;
				oy_nx = '0;
			end else if (oy_q == th_m1) begin
				ty_nx = ty_q + 6'd1;
				oy_nx = '0;
			end else begin
				oy_nx = oy_q + 8'd1;
			end
		end else begin
			if (!cy_q[CXW-1] && cy_u == CMW'(mhth)) begin
				ty_nx = 6'(mh - 7'd1);
				oy_nx = th_m1;
			end else if (oy_q == 8'd0) begin
				ty_nx = ty_q - 6'd1;
				oy_nx = th_m1;
			end else begin
				oy_nx = oy_q - 8'd1;
			end
		end
	end

	always_comb begin
		match = 1'b0;
		for (int i = 0; i < MAX_TARGETS; i++) begin
			if (CNTW'(i) < target_count_q && rd_q == targ_q[i]) match = 1'b1;
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MULX: begin mul_a = 25'(ax_q);   mul_b = 25'(ax_q); end
			ST_MULY: begin mul_a = 25'(ay_q);   mul_b = 25'(ay_q); end
			ST_FX0:  begin mul_a = 25'(part_x); mul_b = 25'(stx_q[18:0]); end
			ST_FX1:  begin mul_a = 25'(part_x); mul_b = 25'(stx_q[37:19]); end
			ST_FY0:  begin mul_a = 25'(part_y); mul_b = 25'(sty_q[18:0]); end
			ST_FY1:  begin mul_a = 25'(part_y); mul_b = 25'(sty_q[37:19]); end
			ST_HX0:  begin mul_a = 25'(ax_q);   mul_b = 25'(dist_q[18:0]); end
			ST_HX1:  begin mul_a = 25'(ax_q);   mul_b = 25'(dist_q[37:19]); end
			ST_HY0:  begin mul_a = 25'(ay_q);   mul_b = 25'(dist_q[18:0]); end
			ST_HY1:  begin mul_a = 25'(ay_q);   mul_b = 25'(dist_q[37:19]); end
			default: begin mul_a = '0;          mul_b = '0; end
		endcase
	end

	// shift-subtract unit requests, operands left aligned
	always_comb begin
		cmd.go = 1'b0;
		cmd.op = tgrt_pkg::OP_DIV;
		cmd.n  = 7'd64;
		cmd.a  = '0;
		cmd.b  = 25'(len_q);
		case (state_q)
			ST_SQRT: begin
				cmd.go = 1'b1;
				cmd.op = tgrt_pkg::OP_SQRT;
				cmd.n  = 7'd25;
				cmd.a  = (acc_q + 64'(prod_q)) << 14;
			end
			ST_DVX: begin
				cmd.go = (ax_q != '0);
				cmd.n  = 7'(25 + FRAC_BITS);
				cmd.a  = 64'(len_q) << 39;
				cmd.b  = 25'(ax_q);
			end
			ST_DVY: begin
				cmd.go = (ay_q != '0);
				cmd.n  = 7'(25 + FRAC_BITS);
				cmd.a  = 64'(len_q) << 39;
				cmd.b  = 25'(ay_q);
			end
			ST_TX: begin
				cmd.go = xin;
				cmd.n  = 7'd14;
				cmd.a  = 64'(cx_u[13:0]) << 50;
				cmd.b  = 25'(tw);
			end
			ST_TY: begin
				cmd.go = yin;
				cmd.n  = 7'd14;
				cmd.a  = 64'(cy_u[13:0]) << 50;
				cmd.b  = 25'(th);
			end
			ST_HX2, ST_HY2: begin
				cmd.go = 1'b1;
				cmd.a  = pair_sum + 64'(len_q >> 1);
			end
			default: cmd.go = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && req.kind == tgrt_pkg::KIND_MAP
				&& slot_ext < XW'(MAP_CELLS)) begin
			tile_mem[slot_ext[AW-1:0]] <= req.tile_value;
		end
		if (state_q == ST_LOOK) begin
			rd_q <= tile_mem[idx_ext[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.kind == tgrt_pkg::KIND_TARGET && req.slot < 12'(MAX_TARGETS)) begin
			targ_q[req.slot[TIW-1:0]] <= req.tile_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q  <= 9'd32;
			tile_height_q <= 9'd32;
			map_width_q   <= 7'd10;
			map_height_q  <= 7'd10;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				tgrt_pkg::REG_TILE_W: tile_width_q  <= pwdata[8:0];
				tgrt_pkg::REG_TILE_H: tile_height_q <= pwdata[8:0];
				tgrt_pkg::REG_MAP_W:  map_width_q   <= pwdata[6:0];
				tgrt_pkg::REG_MAP_H:  map_height_q  <= pwdata[6:0];
				default:              tile_width_q  <= tile_width_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			done_q         <= 1'b0;
			map_loaded_q   <= 1'b0;
			target_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.kind)
							tgrt_pkg::KIND_MAP: begin
								if (slot_ext < XW'(MAP_CELLS)) map_loaded_q <= 1'b1;
							end
							tgrt_pkg::KIND_TARGET: begin
								if (req.slot < 12'(MAX_TARGETS)
										&& (13'(req.slot) + 13'd1) > 13'(target_count_q)) begin
									target_count_q <= CNTW'(13'(req.slot) + 13'd1);
								end
							end
							tgrt_pkg::KIND_CLEAR: begin
								map_loaded_q   <= 1'b0;
								target_count_q <= '0;
							end
							default: begin
								if (!map_loaded_q || target_count_q == '0) done_q <= 1'b1;
								else state_q <= ST_MULX;
							end
						endcase
					end
				end
				ST_MULX: state_q <= ST_MULY;
				ST_MULY: state_q <= ST_SQRT;
				ST_SQRT: state_q <= ST_SQW;
				ST_SQW: begin
					if (rsp.done) begin
						if (rsp.quo[24:0] == '0) begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DVX;
						end
					end
				end
				ST_DVX:  state_q <= (ax_q != '0) ? ST_DVXW : ST_DVY;
				ST_DVXW: if (rsp.done) state_q <= ST_DVY;
				ST_DVY:  state_q <= (ay_q != '0) ? ST_DVYW : ST_FX0;
				ST_DVYW: if (rsp.done) state_q <= ST_FX0;
				ST_FX0:  state_q <= ST_FX1;
				ST_FX1:  state_q <= ST_FX2;
				ST_FX2:  state_q <= ST_FY0;
				ST_FY0:  state_q <= ST_FY1;
				ST_FY1:  state_q <= ST_FY2;
				ST_FY2:  state_q <= ST_TX;
				ST_TX:   state_q <= xin ? ST_TXW : ST_TY;
				ST_TXW:  if (rsp.done) state_q <= ST_TY;
				ST_TY:   state_q <= yin ? ST_TYW : ST_STEP;
				ST_TYW:  if (rsp.done) state_q <= ST_STEP;
				ST_STEP: state_q <= ST_LOOK;
				ST_LOOK: begin
					if (xin && yin && idx_ext < XW'(MAP_CELLS)) begin
						state_q <= ST_CMP;
					end else if (dist_q < DW'(len_q)) begin
						state_q <= ST_STEP;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_CMP: begin
					if (match) begin
						state_q <= ST_HX0;
					end else if (dist_q < DW'(len_q)) begin
						state_q <= ST_STEP;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_HX0: state_q <= ST_HX1;
				ST_HX1: state_q <= ST_HX2;
				ST_HX2: state_q <= ST_HXW;
				ST_HXW: if (rsp.done) state_q <= ST_HY0;
				ST_HY0: state_q <= ST_HY1;
				ST_HY1: state_q <= ST_HY2;
				ST_HY2: state_q <= ST_HYW;
				ST_HYW: begin
					if (rsp.done) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= 50'(mul_a) * 50'(mul_b);
		case (state_q)
			ST_IDLE: begin
				sx_q   <= req.start_x;
				sy_q   <= req.start_y;
				dx_q   <= dx_in;
				dy_q   <= dy_in;
				ax_q   <= dx_in[24] ? 24'(-dx_in) : dx_in[23:0];
				ay_q   <= dy_in[24] ? 24'(-dy_in) : dy_in[23:0];
				cx_q   <= CXW'(cx0);
				cy_q   <= CXW'(cy0);
				dist_q <= '0;
				side_q <= 1'b0;
				res_q  <= '{status: tgrt_pkg::STATUS_NOLOAD, default: '0};
			end
			ST_MULY: acc_q <= 64'(prod_q);
			ST_SQW: begin
				len_q        <= rsp.quo[24:0];
				res_q.status <= tgrt_pkg::STATUS_MISS;
			end
			ST_DVX:  if (ax_q == '0) stx_q <= tgrt_pkg::DIST_SAT;
			ST_DVXW: stx_q <= quo_sat;
			ST_DVY:  if (ay_q == '0) sty_q <= tgrt_pkg::DIST_SAT;
			ST_DVYW: sty_q <= quo_sat;
			ST_FX1, ST_FY1, ST_HX1, ST_HY1: acc_q <= 64'(prod_q);
			ST_FX2:  lx_q <= pair_sum[FRAC_BITS +: DW];
			ST_FY2:  ly_q <= pair_sum[FRAC_BITS +: DW];
			ST_TXW: begin
				tx_q <= rsp.quo[5:0];
				ox_q <= rsp.rem[7:0];
			end
			ST_TYW: begin
				ty_q <= rsp.quo[5:0];
				oy_q <= rsp.rem[7:0];
			end
			ST_STEP: begin
				if (lx_q < ly_q) begin
					cx_q   <= xneg ? (cx_q - CXW'(1)) : (cx_q + CXW'(1));
					tx_q   <= tx_nx;
					ox_q   <= ox_nx;
					dist_q <= lx_q;
					lx_q   <= lx_nx;
					side_q <= 1'b0;
				end else begin
					cy_q   <= yneg ? (cy_q - CXW'(1)) : (cy_q + CXW'(1));
					ty_q   <= ty_nx;
					oy_q   <= oy_nx;
					dist_q <= ly_q;
					ly_q   <= ly_nx;
					side_q <= 1'b1;
				end
			end
			ST_LOOK: idx_q <= idx_c;
			ST_HXW:  if (rsp.done) hx_q <= hit_coord(sx_q, xneg, rsp.quo);
			ST_HYW: begin
				if (rsp.done) begin
					res_q.status         <= tgrt_pkg::STATUS_HIT;
					res_q.hit_tile_x     <= tx_q;
					res_q.hit_tile_y     <= ty_q;
					res_q.hit_tile_index <= idx_q;
					res_q.hit_tile_type  <= rd_q;
					res_q.hit_x          <= hx_q;
					res_q.hit_y          <= hit_coord(sy_q, yneg, rsp.quo);
					res_q.hit_side       <= side_q;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

endmodule
`default_nettype wire

[rtl/tgrt_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
module tgrt_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire tgrt_pkg::req_t req,
	input wire logic           done,
	input wire tgrt_pkg::res_t result
);

	// a result only follows a cast request or the end of a busy stretch
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without a pending request");

	a_cast_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.kind == tgrt_pkg::KIND_CAST) |=> (busy || done))
		else $error("cast request neither started nor answered");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != tgrt_pkg::STATUS_HIT) |->
			(result.hit_tile_x == '0 && result.hit_tile_y == '0
			&& result.hit_tile_index == '0 && result.hit_tile_type == '0
			&& result.hit_x == '0 && result.hit_y == '0 && result.hit_side == 1'b0))
		else $error("miss result carries hit fields");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status == tgrt_pkg::STATUS_HIT || result.status == tgrt_pkg::STATUS_MISS
			|| result.status == tgrt_pkg::STATUS_NOLOAD))
		else $error("bad result status");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.kind != tgrt_pkg::KIND_CAST) |=> !busy)
		else $error("store request left block busy");

endmodule

bind tile_grid_ray_traversal tgrt_chk u_tgrt_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.result (result)
);
`default_nettype wire
